@@ hw/rtl/lrd_pkg.sv @@
`default_nettype none

package lrd_pkg;

    localparam int LEN_BITS_DEFAULT = 24;
    localparam int CFG_W            = 25;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 25'd65536;
    localparam logic [31:0]      HDR_AFTER_LEN = 32'd13;
    localparam logic [31:0]      CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0]      CRC_INIT      = 32'hFFFFFFFF;

    localparam logic [2:0] KIND_KEY       = 3'd0;
    localparam logic [2:0] KIND_VALUE     = 3'd1;
    localparam logic [2:0] KIND_OK        = 3'd2;
    localparam logic [2:0] KIND_CRC_BAD   = 3'd3;
    localparam logic [2:0] KIND_LEN_BAD   = 3'd4;
    localparam logic [2:0] KIND_LOG_END   = 3'd5;
    localparam logic [2:0] KIND_TRUNCATED = 3'd6;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       out_byte;
        logic [7:0]       record_type;
        logic [CFG_W-1:0] key_length;
        logic [CFG_W-1:0] value_length;
        logic             record_last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [7:0]       data;
        logic [7:0]       rtype;
        logic [CFG_W-1:0] klen;
        logic [CFG_W-1:0] vlen;
    } entry_t;

    typedef struct packed {
        logic   v0;
        logic   v1;
        entry_t e0;
        entry_t e1;
    } push_t;

    typedef struct packed {
        logic space2;
        logic nonempty;
    } qstat_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lrd_chan_if.sv @@
`default_nettype none

interface lrd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/log_record_deframer_crc32.sv @@
// channel        dir  payload                                   transaction
// byte_stream    in   req_type, data_byte                       valid && ready
// result_stream  out  kind, out_byte, record_type, key_length,  valid && ready
//                     value_length, record_last
// cfg            in   cfg_wdata (max_record_len)                cfg_we
//
// One log byte per cycle; the bytewise CRC-32 update and field counters set that figure.
// The last value byte yields two results; the back end drains one per cycle unless the output stalls.
// A four-entry queue parts parser from output register; input stalls while fewer
// than two queue slots are free.
// Reset is asynchronous, active low; no clearing pass is needed.
`default_nettype none

module log_record_deframer_crc32 #(
    parameter int LEN_BITS = lrd_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [lrd_pkg::CFG_W-1:0] cfg_wdata,
    lrd_chan_if.sink                       byte_stream,
    lrd_chan_if.source                     result_stream
);

    lrd_pkg::push_t  push;
    lrd_pkg::qstat_t qstat;
    lrd_pkg::entry_t head;
    logic            pop;

    lrd_front #(
        .LEN_BITS(LEN_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_stream(byte_stream),
        .qstat      (qstat),
        .push       (push)
    );

    lrd_queue u_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .pop  (pop),
        .head (head),
        .qstat(qstat)
    );

    lrd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_stream(result_stream)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lrd_front.sv @@
`default_nettype none

module lrd_front #(
    parameter int LEN_BITS = lrd_pkg::LEN_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [lrd_pkg::CFG_W-1:0] cfg_wdata,
    lrd_chan_if.sink                       byte_stream,
    input  lrd_pkg::qstat_t                qstat,
    output lrd_pkg::push_t                 push
);

    localparam int CNT_W = LEN_BITS + 1;
    localparam logic [32:0] LEN_CAP = 33'd1 << LEN_BITS;

    localparam logic [2:0] PH_LEN  = 3'd0;
    localparam logic [2:0] PH_CRC  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_KLEN = 3'd3;
    localparam logic [2:0] PH_KEY  = 3'd4;
    localparam logic [2:0] PH_VLEN = 3'd5;
    localparam logic [2:0] PH_VAL  = 3'd6;

    logic [lrd_pkg::CFG_W-1:0] max_len_reg;
    logic [2:0]                phase_reg, phase_next;
    logic [CNT_W-1:0]          fc_reg, fc_next, fc_inc;
    logic [31:0]               acc_reg, acc_next;
    logic [31:0]               stored_reg, stored_next;
    logic [31:0]               crc_reg, crc_next, crc_upd;
    logic [lrd_pkg::CFG_W-1:0] expect_reg, expect_next;
    logic [lrd_pkg::CFG_W-1:0] klen_reg, klen_next;
    logic [lrd_pkg::CFG_W-1:0] vlen_reg, vlen_next;
    logic [7:0]                type_reg, type_next;
    logic                      halted_reg, halted_next;
    logic                      accept;
    logic                      field_done;
    logic [7:0]                b;
    logic [2:0]                verdict_kind;

    assign byte_stream.ready = qstat.space2;
    assign accept     = byte_stream.valid && byte_stream.ready;
    assign b          = byte_stream.data.data_byte;
    assign fc_inc     = fc_reg + CNT_W'(1);
    assign field_done = (fc_reg[1:0] == 2'd3);
    assign crc_upd    = lrd_pkg::crc_byte(crc_reg, b);
    assign verdict_kind = ((~crc_upd) == stored_reg) ? lrd_pkg::KIND_OK
                                                     : lrd_pkg::KIND_CRC_BAD;

    always_comb
    begin
        acc_next = (fc_reg[1:0] == 2'd0) ? {24'd0, b}
                                         : (acc_reg | (32'(b) << {fc_reg[1:0], 3'b000}));
    end

    always_comb
    begin
        phase_next  = phase_reg;
        fc_next     = fc_reg;
        stored_next = stored_reg;
        crc_next    = crc_reg;
        expect_next = expect_reg;
        klen_next   = klen_reg;
        vlen_next   = vlen_reg;
        type_next   = type_reg;
        halted_next = halted_reg;
        push        = '0;

        if (accept && !halted_reg)
        begin
            if (byte_stream.data.req_type)
            begin
                push.v0      = 1'b1;
                push.e0.kind = (phase_reg == PH_LEN && fc_reg == '0) ? lrd_pkg::KIND_LOG_END
                                                                     : lrd_pkg::KIND_TRUNCATED;
                phase_next = PH_LEN;
                fc_next    = '0;
                crc_next   = lrd_pkg::CRC_INIT;
                klen_next  = '0;
                vlen_next  = '0;
                type_next  = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN:
                    begin
                        fc_next = fc_inc;
                        if (field_done)
                        begin
                            fc_next = '0;
                            if (acc_next < lrd_pkg::HDR_AFTER_LEN ||
                                acc_next > {7'd0, max_len_reg} ||
                                {1'b0, acc_next} > LEN_CAP)
                            begin
                                push.v0       = 1'b1;
                                push.e0.kind  = lrd_pkg::KIND_LEN_BAD;
                                push.e0.rtype = type_reg;
                                halted_next   = 1'b1;
                            end
                            else
                            begin
                                expect_next = lrd_pkg::CFG_W'(acc_next - lrd_pkg::HDR_AFTER_LEN);
                                phase_next  = PH_CRC;
                            end
                        end
                    end
                    PH_CRC:
                    begin
                        fc_next = fc_inc;
                        if (field_done)
                        begin
                            fc_next     = '0;
                            stored_next = acc_next;
                            phase_next  = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        crc_next   = crc_upd;
                        type_next  = b;
                        phase_next = PH_KLEN;
                    end
                    PH_KLEN:
                    begin
                        crc_next = crc_upd;
                        fc_next  = fc_inc;
                        if (field_done)
                        begin
                            fc_next = '0;
                            if (acc_next > 32'(expect_reg))
                            begin
                                push.v0       = 1'b1;
                                push.e0.kind  = lrd_pkg::KIND_LEN_BAD;
                                push.e0.rtype = type_reg;
                                halted_next   = 1'b1;
                            end
                            else
                            begin
                                klen_next   = lrd_pkg::CFG_W'(acc_next);
                                expect_next = expect_reg - lrd_pkg::CFG_W'(acc_next);
                                phase_next  = (acc_next == 32'd0) ? PH_VLEN : PH_KEY;
                            end
                        end
                    end
                    PH_KEY:
                    begin
                        crc_next      = crc_upd;
                        push.v0       = 1'b1;
                        push.e0.kind  = lrd_pkg::KIND_KEY;
                        push.e0.data  = b;
                        push.e0.rtype = type_reg;
                        push.e0.klen  = klen_reg;
                        fc_next       = fc_inc;
                        if (33'(fc_inc) == 33'(klen_reg))
                        begin
                            fc_next    = '0;
                            phase_next = PH_VLEN;
                        end
                    end
                    PH_VLEN:
                    begin
                        crc_next = crc_upd;
                        fc_next  = fc_inc;
                        if (field_done)
                        begin
                            fc_next = '0;
                            if (acc_next != 32'(expect_reg))
                            begin
                                push.v0       = 1'b1;
                                push.e0.kind  = lrd_pkg::KIND_LEN_BAD;
                                push.e0.rtype = type_reg;
                                halted_next   = 1'b1;
                            end
                            else if (acc_next == 32'd0)
                            begin
                                push.v0       = 1'b1;
                                push.e0.kind  = verdict_kind;
                                push.e0.rtype = type_reg;
                                push.e0.klen  = klen_reg;
                                halted_next   = (verdict_kind == lrd_pkg::KIND_CRC_BAD);
                                phase_next    = PH_LEN;
                                crc_next      = lrd_pkg::CRC_INIT;
                                klen_next     = '0;
                                vlen_next     = '0;
                                type_next     = '0;
                            end
                            else
                            begin
                                vlen_next  = lrd_pkg::CFG_W'(acc_next);
                                phase_next = PH_VAL;
                            end
                        end
                    end
                    PH_VAL:
                    begin
                        crc_next      = crc_upd;
                        push.v0       = 1'b1;
                        push.e0.kind  = lrd_pkg::KIND_VALUE;
                        push.e0.data  = b;
                        push.e0.rtype = type_reg;
                        push.e0.klen  = klen_reg;
                        push.e0.vlen  = vlen_reg;
                        fc_next       = fc_inc;
                        if (33'(fc_inc) == 33'(vlen_reg))
                        begin
                            push.v1       = 1'b1;
                            push.e1.kind  = verdict_kind;
                            push.e1.rtype = type_reg;
                            push.e1.klen  = klen_reg;
                            push.e1.vlen  = vlen_reg;
                            halted_next   = (verdict_kind == lrd_pkg::KIND_CRC_BAD);
                            phase_next    = PH_LEN;
                            fc_next       = '0;
                            crc_next      = lrd_pkg::CRC_INIT;
                            klen_next     = '0;
                            vlen_next     = '0;
                            type_next     = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_LEN;
                        fc_next    = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= lrd_pkg::MAX_LEN_RESET;
            phase_reg   <= PH_LEN;
            fc_reg      <= '0;
            crc_reg     <= lrd_pkg::CRC_INIT;
            klen_reg    <= '0;
            vlen_reg    <= '0;
            type_reg    <= '0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_len_reg <= cfg_wdata;
            end
            phase_reg  <= phase_next;
            fc_reg     <= fc_next;
            crc_reg    <= crc_next;
            klen_reg   <= klen_next;
            vlen_reg   <= vlen_next;
            type_reg   <= type_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= acc_next;
        end
        stored_reg <= stored_next;
        expect_reg <= expect_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lrd_queue.sv @@
`default_nettype none

module lrd_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  lrd_pkg::push_t push,
    input  wire logic      pop,
    output lrd_pkg::entry_t head,
    output lrd_pkg::qstat_t qstat
);

    localparam int DEPTH = lrd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lrd_pkg::entry_t  q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr1;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign wr_ptr1        = wr_ptr_reg + PTR_W'(1);
    assign head           = q_reg[rd_ptr_reg];
    assign qstat.nonempty = (count_reg != '0);
    assign qstat.space2   = (count_reg <= CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.v0) + PTR_W'(push.v1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.v0) + CNT_W'(push.v1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            q_reg[wr_ptr_reg] <= push.e0;
        end
        if (push.v1)
        begin
            q_reg[wr_ptr1] <= push.e1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue overflow");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second push without first");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("pop from empty queue");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> qstat.space2)
        else $error("push without room for two entries");

endmodule

`default_nettype wire

@@ hw/rtl/lrd_back.sv @@
`default_nettype none

module lrd_back (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  lrd_pkg::entry_t head,
    input  lrd_pkg::qstat_t qstat,
    output logic            pop,
    lrd_chan_if.source      result_stream
);

    logic                valid_reg;
    lrd_pkg::out_item_t  item_reg, item_next;

    assign pop = qstat.nonempty && (!valid_reg || result_stream.ready);

    always_comb
    begin
        item_next.kind         = head.kind;
        item_next.out_byte     = head.data;
        item_next.record_type  = head.rtype;
        item_next.key_length   = head.klen;
        item_next.value_length = head.vlen;
        item_next.record_last  = (head.kind != lrd_pkg::KIND_KEY) &&
                                 (head.kind != lrd_pkg::KIND_VALUE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || result_stream.ready)
        begin
            valid_reg <= qstat.nonempty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item_next;
        end
    end

    assign result_stream.valid = valid_reg;
    assign result_stream.data  = item_reg;

endmodule

`default_nettype wire
